### rtl/tarc_pkg.sv
// ----------------------------------------------------------------------------
// tarc_pkg: shared types and constants of the axis rate controller
// Mode codes, operation codes, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tarc_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_TRACK  = 3'd1,
        MODE_LOCK   = 3'd2,
        MODE_SEARCH = 3'd3,
        MODE_TRACE  = 3'd4,
        MODE_SCAN   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        OP_FEED   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_FORCE  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INT_GAIN   = 3'd1,
        REG_STOP_BAND  = 3'd2,
        REG_START_BAND = 3'd3,
        REG_MAX_RATE   = 3'd4,
        REG_MIN_RATE   = 3'd5,
        REG_LOCK_BAND  = 3'd6,
        REG_DEBOUNCE   = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_EXEC  = 3'd1,
        ST_MUL1  = 3'd2,
        ST_MUL2  = 3'd3,
        ST_MUL3  = 3'd4,
        ST_FIN   = 3'd5,
        ST_OUT   = 3'd6
    } state_t;

    // Q12.20 integral limit: 60 * 2^20
    localparam logic signed [33:0] INT_LIMIT = 34'sd62914560;

    typedef struct packed {
        logic load;    // capture request payload
        logic exec;    // feed/force/mode transitions and setup
        logic mul1;    // prod = e * ts and p = prop_gain * e
        logic mul2;    // acc clamp and i = int_gain * acc
        logic mul3;    // out sum, clamp, back-off
        logic fin;     // final rate, commit
    } dp_cmd_t;

    typedef struct packed {
        logic need_pi; // update request needs the PI path
    } dp_stat_t;

endpackage

### rtl/tarc_ctrl.sv
// ----------------------------------------------------------------------------
// tarc_ctrl: request sequencer
// Steps each accepted request through the datapath and holds the result
// register until the result is taken.
// ----------------------------------------------------------------------------
module tarc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  tarc_pkg::dp_stat_t  stat,
    output tarc_pkg::dp_cmd_t   cmd
);

    tarc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tarc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tarc_pkg::ST_IDLE: if (s_valid) state_next = tarc_pkg::ST_EXEC;
            tarc_pkg::ST_EXEC: begin
                if (stat.need_pi) state_next = tarc_pkg::ST_MUL1;
                else state_next = tarc_pkg::ST_FIN;
            end
            tarc_pkg::ST_MUL1: state_next = tarc_pkg::ST_MUL2;
            tarc_pkg::ST_MUL2: state_next = tarc_pkg::ST_MUL3;
            tarc_pkg::ST_MUL3: state_next = tarc_pkg::ST_FIN;
            tarc_pkg::ST_FIN:  state_next = tarc_pkg::ST_OUT;
            tarc_pkg::ST_OUT:  if (m_ready) state_next = tarc_pkg::ST_IDLE;
            default:           state_next = tarc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            tarc_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            tarc_pkg::ST_EXEC: cmd.exec = 1'b1;
            tarc_pkg::ST_MUL1: cmd.mul1 = 1'b1;
            tarc_pkg::ST_MUL2: cmd.mul2 = 1'b1;
            tarc_pkg::ST_MUL3: cmd.mul3 = 1'b1;
            tarc_pkg::ST_FIN:  cmd.fin  = 1'b1;
            tarc_pkg::ST_OUT:  m_valid  = 1'b1;
            default: ;
        endcase
    end

endmodule

### rtl/tarc_dp.sv
// ----------------------------------------------------------------------------
// tarc_dp: axis rate datapath
// Config registers, mode and debounce state, PI and proportional paths.
// ----------------------------------------------------------------------------
module tarc_dp #(
    parameter int SCAN_RATE         = 150,
    parameter int SEARCH_RATE       = 100,
    parameter int SEARCH_TIMEOUT_MS = 1500,
    parameter int SCAN_AXIS         = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  tarc_pkg::dp_cmd_t   cmd,
    output tarc_pkg::dp_stat_t  stat,
    input  logic [1:0]          s_operation,
    input  logic                s_target_lost,
    input  logic                s_target_zero,
    input  logic signed [15:0]  s_error,
    input  logic [15:0]         s_time_step,
    input  logic [31:0]         s_now_ms,
    input  logic                s_enabled,
    input  logic [2:0]          s_new_mode,
    output logic [11:0]         m_rate_hz,
    output logic                m_direction,
    output logic                m_locked,
    output logic [2:0]          m_mode
);

    // config
    logic [15:0] prop_gain_reg, int_gain_reg;
    logic [14:0] stop_band_reg, start_band_reg, lock_band_reg;
    logic [11:0] max_rate_reg, min_rate_reg;
    logic [7:0]  debounce_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= '0;
            int_gain_reg   <= '0;
            stop_band_reg  <= 15'd64;
            start_band_reg <= 15'd192;
            max_rate_reg   <= 12'd600;
            min_rate_reg   <= 12'd50;
            lock_band_reg  <= 15'd48;
            debounce_reg   <= 8'd15;
        end else if (cfg_valid) begin
            case (tarc_pkg::reg_idx_t'(cfg_index))
                tarc_pkg::REG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                tarc_pkg::REG_INT_GAIN:   int_gain_reg   <= cfg_data;
                tarc_pkg::REG_STOP_BAND:  stop_band_reg  <= cfg_data[14:0];
                tarc_pkg::REG_START_BAND: start_band_reg <= cfg_data[14:0];
                tarc_pkg::REG_MAX_RATE:   max_rate_reg   <= cfg_data[11:0];
                tarc_pkg::REG_MIN_RATE:   min_rate_reg   <= cfg_data[11:0];
                tarc_pkg::REG_LOCK_BAND:  lock_band_reg  <= cfg_data[14:0];
                tarc_pkg::REG_DEBOUNCE:   debounce_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // captured request
    logic [1:0]         op_reg;
    logic               lost_in_reg, zero_in_reg, en_reg;
    logic signed [15:0] e_reg;
    logic [15:0]        ts_reg;
    logic [31:0]        now_reg;
    logic [2:0]         nm_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_operation;
            lost_in_reg <= s_target_lost;
            zero_in_reg <= s_target_zero;
            e_reg       <= s_error;
            ts_reg      <= s_time_step;
            now_reg     <= s_now_ms;
            en_reg      <= s_enabled;
            nm_reg      <= s_new_mode;
        end
    end

    // state
    tarc_pkg::mode_t    mode_reg;
    logic               stopped_reg, chase_reg, dir_reg, pi_reg, upd_reg;
    logic [7:0]         lost_reg, found_reg;
    logic [31:0]        search_start_reg;
    logic signed [31:0] integral_reg;
    logic [15:0]        smooth_reg;
    logic [11:0]        rate_reg;

    logic [15:0] ae;
    assign ae = e_reg[15] ? 16'(-e_reg) : 16'(e_reg);

    logic [31:0] elapsed;
    assign elapsed = now_reg - search_start_reg;

    // mode after transitions
    tarc_pkg::mode_t mode_x;
    logic clr_int_x, clr_stop_x, to_search_x;
    always_comb begin
        mode_x      = mode_reg;
        clr_int_x   = 1'b0;
        clr_stop_x  = 1'b0;
        to_search_x = 1'b0;
        case (mode_reg)
            tarc_pkg::MODE_IDLE: begin
                if (en_reg && found_reg >= debounce_reg) begin
                    mode_x = tarc_pkg::MODE_TRACK; clr_int_x = 1'b1; clr_stop_x = 1'b1;
                end
            end
            tarc_pkg::MODE_LOCK, tarc_pkg::MODE_TRACK, tarc_pkg::MODE_TRACE: begin
                if (lost_reg >= debounce_reg) begin
                    mode_x = tarc_pkg::MODE_SEARCH; clr_int_x = 1'b1; to_search_x = 1'b1;
                end
            end
            tarc_pkg::MODE_SEARCH: begin
                if (found_reg >= debounce_reg) begin
                    mode_x = tarc_pkg::MODE_TRACK; clr_int_x = 1'b1; clr_stop_x = 1'b1;
                end else if (!elapsed[31] && elapsed >= 32'(SEARCH_TIMEOUT_MS)) begin
                    mode_x = tarc_pkg::MODE_IDLE;
                end
            end
            default: ;
        endcase
    end

    // track stop/start hysteresis
    logic stopped_x, pi_x;
    always_comb begin
        logic st;
        st = stopped_reg && !clr_stop_x;
        stopped_x = st;
        pi_x      = 1'b0;
        if (mode_x == tarc_pkg::MODE_TRACK) begin
            if (st) begin
                if (ae > {1'b0, start_band_reg}) begin
                    stopped_x = 1'b0; pi_x = 1'b1;
                end
            end else if (ae < {1'b0, stop_band_reg}) begin
                stopped_x = 1'b1;
            end else begin
                pi_x = 1'b1;
            end
        end
    end

    assign stat.need_pi = (tarc_pkg::op_t'(op_reg) == tarc_pkg::OP_UPDATE) && pi_x;

    // PI arithmetic, split over the mul1, mul2 and mul3 steps
    logic signed [31:0] prod_reg;   // e * ts, Q12.20
    logic signed [33:0] p_reg;      // prop_gain * e, << 16 applied later
    logic signed [33:0] acc_reg;
    logic signed [49:0] i_reg;      // int_gain * acc
    logic signed [51:0] out_reg;

    logic signed [33:0] acc_raw, acc_cl;
    assign acc_raw = 34'(integral_reg) + 34'(prod_reg);
    assign acc_cl  = (acc_raw > tarc_pkg::INT_LIMIT) ? tarc_pkg::INT_LIMIT :
                     (acc_raw < -tarc_pkg::INT_LIMIT) ? -tarc_pkg::INT_LIMIT : acc_raw;

    logic signed [51:0] out_sum, lim;
    assign out_sum = (52'(p_reg) <<< 16) + 52'(i_reg);
    assign lim     = 52'($signed({1'b0, max_rate_reg})) <<< 28;

    // proportional target; 4 * |e| needs 19 bits signed
    logic signed [18:0] tgt, lo, hi, stp, tgt_c;
    always_comb begin
        if (mode_reg == tarc_pkg::MODE_LOCK) begin
            tgt = 19'($signed({3'b0, ae}) <<< 2);
            lo = 19'sd256; hi = 19'sd3200; stp = 19'sd160;
        end else begin
            tgt = $signed({3'b0, ae});
            lo = 19'sd128; hi = 19'sd800; stp = 19'sd96;
        end
        tgt_c = (tgt < lo) ? lo : (tgt > hi) ? hi : tgt;
    end
    logic signed [18:0] sm_s;
    logic [15:0] sm_new;
    logic [10:0] sm_hz;
    assign sm_s   = 19'($signed(smooth_reg));
    assign sm_new = (tgt_c > sm_s + stp || tgt_c < sm_s - stp) ?
                    16'(tgt_c) : smooth_reg;
    assign sm_hz  = sm_new[15] ? 11'd0 : sm_new[15:5];

    logic signed [51:0] mag;
    logic [23:0] pi_hz;
    assign mag   = out_reg[51] ? -out_reg : out_reg;
    assign pi_hz = mag[51:28];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= tarc_pkg::MODE_IDLE;
            stopped_reg  <= 1'b0;
            lost_reg     <= '0;
            found_reg    <= '0;
            chase_reg    <= 1'b1;
            integral_reg <= '0;
            smooth_reg   <= '0;
            rate_reg     <= '0;
            dir_reg      <= 1'b0;
            pi_reg       <= 1'b0;
            upd_reg      <= 1'b0;
        end else begin
            if (cmd.exec) begin
                upd_reg <= 1'b0;
                case (tarc_pkg::op_t'(op_reg))
                    tarc_pkg::OP_FEED: begin
                        if (lost_in_reg) begin
                            if (lost_reg != 8'hFF) lost_reg <= lost_reg + 8'd1;
                            found_reg <= '0;
                        end else if (!zero_in_reg) begin
                            if (found_reg != 8'hFF) found_reg <= found_reg + 8'd1;
                            lost_reg <= '0;
                        end
                    end
                    tarc_pkg::OP_FORCE: begin
                        if (nm_reg <= 3'(tarc_pkg::MODE_SCAN)) begin
                            mode_reg     <= tarc_pkg::mode_t'(nm_reg);
                            integral_reg <= '0;
                            stopped_reg  <= 1'b0;
                            lost_reg     <= '0;
                            found_reg    <= '0;
                            smooth_reg   <= '0;
                        end
                    end
                    tarc_pkg::OP_UPDATE: begin
                        upd_reg     <= 1'b1;
                        mode_reg    <= mode_x;
                        stopped_reg <= stopped_x;
                        pi_reg      <= pi_x;
                        if (to_search_x) begin
                            chase_reg        <= dir_reg;
                            search_start_reg <= now_reg;
                        end
                        if (clr_int_x || (mode_x == tarc_pkg::MODE_TRACK && !pi_x))
                            integral_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.mul2) integral_reg <= 32'(acc_cl);
            if (cmd.mul3) begin
                // anti-windup: back the product out of the clamped accumulator
                if (out_sum > lim || out_sum < -lim)
                    integral_reg <= 32'(acc_reg - 34'(prod_reg));
            end
            if (cmd.fin && upd_reg) begin
                case (mode_reg)
                    tarc_pkg::MODE_SCAN: begin
                        rate_reg <= (SCAN_AXIS == 1) ? 12'(SCAN_RATE) : 12'd0;
                        dir_reg  <= (SCAN_AXIS == 1);
                    end
                    tarc_pkg::MODE_SEARCH: begin
                        rate_reg <= 12'(SEARCH_RATE);
                        dir_reg  <= chase_reg;
                    end
                    tarc_pkg::MODE_LOCK, tarc_pkg::MODE_TRACE: begin
                        if (ae <= {1'b0, lock_band_reg}) begin
                            rate_reg <= '0; dir_reg <= 1'b0; smooth_reg <= '0;
                        end else begin
                            dir_reg    <= !e_reg[15] && (e_reg != 16'sd0);
                            smooth_reg <= sm_new;
                            rate_reg   <= (sm_hz == 11'd0) ? 12'd1 : {1'b0, sm_hz};
                        end
                    end
                    tarc_pkg::MODE_TRACK: begin
                        if (!pi_reg) begin
                            rate_reg <= '0; dir_reg <= 1'b0;
                        end else begin
                            logic [23:0] h;
                            h = pi_hz;
                            if (h < 24'(min_rate_reg)) h = 24'(min_rate_reg);
                            if (h > 24'(max_rate_reg)) h = 24'(max_rate_reg);
                            rate_reg <= h[11:0];
                            dir_reg  <= !out_reg[51] && (out_reg != '0);
                        end
                    end
                    default: begin
                        rate_reg <= '0; dir_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    // multiplier pipeline registers
    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            prod_reg <= 32'(34'(e_reg) * 34'($signed({1'b0, ts_reg})));
            p_reg    <= 34'($signed({1'b0, prop_gain_reg})) * 34'(e_reg);
        end
        if (cmd.mul2) begin
            acc_reg <= acc_cl;
            i_reg   <= 50'($signed({1'b0, int_gain_reg})) * 50'(acc_cl);
        end
        if (cmd.mul3) begin
            out_reg <= (out_sum > lim) ? lim : (out_sum < -lim) ? -lim : out_sum;
        end
    end

    assign m_rate_hz   = rate_reg;
    assign m_direction = dir_reg;
    assign m_mode      = mode_reg;
    assign m_locked    = (mode_reg == tarc_pkg::MODE_LOCK || mode_reg == tarc_pkg::MODE_TRACE)
                         && rate_reg == 12'd0;

endmodule

### rtl/tracking_axis_rate_controller_unit.sv
// ----------------------------------------------------------------------------
// tracking_axis_rate_controller_unit: one stepper axis rate controller
// Feed, update and force requests; one result per request.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  s_       | in        | s_valid/s_ready    | operation..new_mode
//  m_       | out       | m_valid/m_ready    | rate_hz, direction, locked, mode
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A feed, force or non-PI update goes through exec and fin before the result
// is valid; a PI update in track mode also goes through mul1, mul2 and mul3.
// The next request can be taken in the cycle after the result is taken.
// Reset (aresetn low, synchronous) loads the register defaults and idle mode.
// A stalled m_ready holds the result and blocks new requests.
module tracking_axis_rate_controller_unit #(
    parameter int SCAN_RATE         = 150,
    parameter int SEARCH_RATE       = 100,
    parameter int SEARCH_TIMEOUT_MS = 1500,
    parameter int SCAN_AXIS         = 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic               s_target_lost,
    input  logic               s_target_zero,
    input  logic signed [15:0] s_error,
    input  logic [15:0]        s_time_step,
    input  logic [31:0]        s_now_ms,
    input  logic               s_enabled,
    input  logic [2:0]         s_new_mode,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [11:0]        m_rate_hz,
    output logic               m_direction,
    output logic               m_locked,
    output logic [2:0]         m_mode
);

    tarc_pkg::dp_cmd_t  cmd;
    tarc_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    tarc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .stat(stat), .cmd(cmd)
    );

    tarc_dp #(
        .SCAN_RATE(SCAN_RATE), .SEARCH_RATE(SEARCH_RATE),
        .SEARCH_TIMEOUT_MS(SEARCH_TIMEOUT_MS), .SCAN_AXIS(SCAN_AXIS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd(cmd), .stat(stat),
        .s_operation(s_operation), .s_target_lost(s_target_lost),
        .s_target_zero(s_target_zero), .s_error(s_error),
        .s_time_step(s_time_step), .s_now_ms(s_now_ms),
        .s_enabled(s_enabled), .s_new_mode(s_new_mode),
        .m_rate_hz(m_rate_hz), .m_direction(m_direction),
        .m_locked(m_locked), .m_mode(m_mode)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("request taken while result pending");

    a_locked_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_locked |-> (m_rate_hz == 12'd0)) else $error("locked with nonzero rate");

    a_mode_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_mode <= 3'(tarc_pkg::MODE_SCAN)))
        else $error("mode code out of range");

endmodule

### sim/tracking_axis_rate_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// tracking_axis_rate_controller_unit_tb: self-checking bench for the axis
// rate controller. A directed table is run first, followed by phased random
// traffic under several register settings. Each accepted request is modeled
// in-bench, and every result is compared field by field in order.
// ----------------------------------------------------------------------------
module tracking_axis_rate_controller_unit_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 12;

    typedef struct {
        tarc_pkg::op_t      op;
        bit                 lost;
        bit                 zero;
        logic signed [15:0] err;
        logic [15:0]        ts;
        logic [31:0]        now;
        bit                 en;
        logic [2:0]         nm;
    } req_t;

    typedef struct {
        logic [11:0] rate;
        logic        dir;
        logic        lk;
        logic [2:0]  mode;
    } status_t;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [1:0]         s_operation = '0;
    logic               s_target_lost = 0;
    logic               s_target_zero = 0;
    logic signed [15:0] s_error = '0;
    logic [15:0]        s_time_step = '0;
    logic [31:0]        s_now_ms = '0;
    logic               s_enabled = 0;
    logic [2:0]         s_new_mode = '0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [11:0]        m_rate_hz;
    logic               m_direction;
    logic               m_locked;
    logic [2:0]         m_mode;

    tracking_axis_rate_controller_unit dut (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    // register copies
    int unsigned kp, ki, band_stop, band_start, rate_max, rate_min, band_lock, debounce;
    // axis state copies
    logic [2:0]  cur_mode;
    bit          hold_stopped, hunt_dir, hunt_start_known, dir_q;
    int unsigned miss_cnt, seen_cnt;
    logic [31:0] hunt_start_ms;
    int          integ, smooth;
    logic [11:0] rate_q;

    status_t     status_q[$];
    int          errors = 0;
    bit          calm = 0;
    logic [31:0] clock_ms;

    function automatic void axis_reset();
        kp = 0; ki = 0; band_stop = 64; band_start = 192;
        rate_max = 600; rate_min = 50; band_lock = 48; debounce = 15;
        cur_mode = tarc_pkg::MODE_IDLE; hold_stopped = 0; miss_cnt = 0; seen_cnt = 0;
        hunt_dir = 1; hunt_start_ms = '0; hunt_start_known = 0; integ = 0; smooth = 0;
        rate_q = '0; dir_q = 0;
    endfunction

    function automatic longint pi_output(int e, int unsigned ts);
        longint prod, acc, lim, out, ilim;
        ilim = longint'(60) * 1048576;
        prod = longint'(e) * longint'(ts);
        acc  = longint'(integ) + prod;
        lim  = longint'(rate_max) <<< 28;
        if (acc > ilim) acc = ilim;
        if (acc < -ilim) acc = -ilim;
        out = longint'(kp) * longint'(e) * 65536 + longint'(ki) * acc;
        if (out > lim) begin
            out = lim; acc -= prod;
        end
        if (out < -lim) begin
            out = -lim; acc -= prod;
        end
        integ = int'(acc);
        return out;
    endfunction

    // lock/trace: target and step are Q.5
    function automatic void follow(int e, int ae, int tgt, int lo, int hi, int stp,
                                   output int hz, output bit dir);
        int r;
        if (ae <= int'(band_lock)) begin
            hz = 0; dir = 0; smooth = 0;
            return;
        end
        dir = e > 0;
        if (tgt < lo) tgt = lo;
        if (tgt > hi) tgt = hi;
        if (tgt > smooth + stp || tgt < smooth - stp) smooth = tgt;
        r = smooth > 0 ? smooth >>> 5 : 0;
        if (r < 1) r = 1;
        hz = r;
    endfunction

    function automatic void run_update(req_t rq);
        int     e, ae, hz;
        bit     dir;
        longint out, mag;
        e = rq.err; ae = e < 0 ? -e : e; hz = 0; dir = 0;
        case (cur_mode)
            tarc_pkg::MODE_IDLE: if (rq.en && seen_cnt >= debounce) begin
                cur_mode = tarc_pkg::MODE_TRACK; hold_stopped = 0; integ = 0;
            end
            tarc_pkg::MODE_LOCK, tarc_pkg::MODE_TRACK, tarc_pkg::MODE_TRACE:
            if (miss_cnt >= debounce) begin
                hunt_dir = dir_q; cur_mode = tarc_pkg::MODE_SEARCH;
                hunt_start_ms = rq.now; hunt_start_known = 1; integ = 0;
            end
            tarc_pkg::MODE_SEARCH: begin
                if (seen_cnt >= debounce) begin
                    cur_mode = tarc_pkg::MODE_TRACK; integ = 0; hold_stopped = 0;
                end else if ((rq.now - hunt_start_ms) < 32'h8000_0000 &&
                             (rq.now - hunt_start_ms) >= 32'd1500) begin
                    cur_mode = tarc_pkg::MODE_IDLE;
                end
            end
            default: ;
        endcase
        case (cur_mode)
            tarc_pkg::MODE_SCAN: begin
                dir = 1; hz = 150;
            end
            tarc_pkg::MODE_SEARCH: begin
                dir = hunt_dir; hz = 100;
            end
            tarc_pkg::MODE_LOCK:  follow(e, ae, 4 * ae, 256, 3200, 160, hz, dir);
            tarc_pkg::MODE_TRACE: follow(e, ae, ae, 128, 800, 96, hz, dir);
            tarc_pkg::MODE_TRACK: begin
                bit skip;
                skip = 0;
                if (hold_stopped) begin
                    if (ae > int'(band_start)) hold_stopped = 0;
                    else begin
                        integ = 0; skip = 1;
                    end
                end else if (ae < int'(band_stop)) begin
                    hold_stopped = 1; integ = 0; skip = 1;
                end
                if (!skip) begin
                    longint h;
                    out = pi_output(e, rq.ts);
                    dir = out > 0;
                    mag = out < 0 ? -out : out;
                    h = mag >>> 28;
                    if (h < rate_min) h = rate_min;
                    if (h > rate_max) h = rate_max;
                    hz = int'(h);
                end
            end
            default: ;
        endcase
        rate_q = hz[11:0];
        dir_q  = dir;
    endfunction

    function automatic status_t axis_step(req_t rq);
        status_t st;
        case (rq.op)
            tarc_pkg::OP_FEED: begin
                if (rq.lost) begin
                    if (miss_cnt < 255) miss_cnt++;
                    seen_cnt = 0;
                end else if (!rq.zero) begin
                    if (seen_cnt < 255) seen_cnt++;
                    miss_cnt = 0;
                end
            end
            tarc_pkg::OP_UPDATE: run_update(rq);
            tarc_pkg::OP_FORCE: if (rq.nm <= tarc_pkg::MODE_SCAN) begin
                cur_mode = rq.nm; integ = 0; hold_stopped = 0;
                miss_cnt = 0; seen_cnt = 0; smooth = 0;
            end
            default: ;
        endcase
        st.rate = rate_q;
        st.dir  = dir_q;
        st.lk   = (cur_mode == tarc_pkg::MODE_LOCK || cur_mode == tarc_pkg::MODE_TRACE)
                  && rate_q == 0;
        st.mode = cur_mode;
        return st;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side
    int stall_left = 0;
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            status_t x;
            if (status_q.size() == 0) begin
                $display("%0t: unexpected result rate=%0d dir=%0d lk=%0d mode=%0d",
                         $time, m_rate_hz, m_direction, m_locked, m_mode);
                errors++;
            end else begin
                x = status_q.pop_front();
                if (m_rate_hz !== x.rate) begin
                    $display("%0t: rate_hz exp %0d got %0d", $time, x.rate, m_rate_hz);
                    errors++;
                end
                if (m_direction !== x.dir) begin
                    $display("%0t: direction exp %0d got %0d", $time, x.dir, m_direction);
                    errors++;
                end
                if (m_locked !== x.lk) begin
                    $display("%0t: locked exp %0d got %0d", $time, x.lk, m_locked);
                    errors++;
                end
                if (m_mode !== x.mode) begin
                    $display("%0t: mode exp %0d got %0d", $time, x.mode, m_mode);
                    errors++;
                end
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (aresetn) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tracking_axis_rate_controller_unit_tb: errors");
                $finish;
            end
        end
    end

    // issue one request; typed-in expectation used when given
    task automatic send(req_t rq, bit typed, status_t want);
        status_t st;
        int g;
        s_operation   = rq.op;
        s_target_lost = rq.lost;
        s_target_zero = rq.zero;
        s_error       = rq.err;
        s_time_step   = rq.ts;
        s_now_ms      = rq.now;
        s_enabled     = rq.en;
        s_new_mode    = rq.nm;
        s_valid       = 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        st = axis_step(rq);
        status_q.push_back(typed ? want : st);
        @(negedge aclk);
        g = pick_gap();
        if (g > 0) begin
            s_valid = 0;
            repeat (g) @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_valid = 0;
        while (status_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(tarc_pkg::reg_idx_t idx, logic [15:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            tarc_pkg::REG_PROP_GAIN:  kp = val;
            tarc_pkg::REG_INT_GAIN:   ki = val;
            tarc_pkg::REG_STOP_BAND:  band_stop = val[14:0];
            tarc_pkg::REG_START_BAND: band_start = val[14:0];
            tarc_pkg::REG_MAX_RATE:   rate_max = val[11:0];
            tarc_pkg::REG_MIN_RATE:   rate_min = val[11:0];
            tarc_pkg::REG_LOCK_BAND:  band_lock = val[14:0];
            default:                  debounce = val[7:0];
        endcase
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    function automatic logic signed [15:0] rand_err();
        int s;
        if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 65535));
        s = $urandom_range(0, 800);
        return 16'(s - 400);
    endfunction

    function automatic req_t rand_req(tarc_pkg::op_t op);
        req_t rq;
        rq.op = op;
        rq.lost = 1'($urandom_range(0, 1));
        rq.zero = 1'($urandom_range(0, 1));
        rq.err = rand_err();
        rq.ts = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                     : 16'($urandom_range(0, 3000));
        case ($urandom_range(0, 19))
            0:       clock_ms = clock_ms + 32'h9000_0000;  // far jump
            1:       clock_ms = clock_ms + 32'($urandom_range(1400, 1600));
            default: clock_ms = clock_ms + 32'($urandom_range(0, 400));
        endcase
        rq.now = clock_ms;
        rq.en = $urandom_range(0, 3) != 0;
        rq.nm = 3'($urandom_range(0, 7));
        return rq;
    endfunction

    // never let a timeout check read an unwritten search start time
    task automatic send_rand(req_t rq);
        status_t none;
        if (rq.op == tarc_pkg::OP_UPDATE && cur_mode == tarc_pkg::MODE_SEARCH &&
            !hunt_start_known && seen_cnt < debounce)
            rq.op = tarc_pkg::OP_FEED;
        send(rq, 0, none);
    endtask

    task automatic run_phase(int n_req);
        int done, k, n;
        req_t rq;
        done = 0;
        while (done < n_req) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    n = debounce + $urandom_range(0, 3);
                    for (k = 0; k < n; k++) begin
                        rq = rand_req(tarc_pkg::OP_FEED);
                        rq.lost = 0;
                        rq.zero = $urandom_range(0, 7) == 0;
                        send_rand(rq);
                    end
                    rq = rand_req(tarc_pkg::OP_UPDATE);
                    rq.en = 1;
                    send_rand(rq);
                    done += n + 1;
                end
                3, 4: begin
                    n = debounce + $urandom_range(0, 3);
                    for (k = 0; k < n; k++) begin
                        rq = rand_req(tarc_pkg::OP_FEED);
                        rq.lost = 1;
                        send_rand(rq);
                    end
                    send_rand(rand_req(tarc_pkg::OP_UPDATE));
                    done += n + 1;
                end
                5, 6, 7: begin
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++) send_rand(rand_req(tarc_pkg::OP_UPDATE));
                    done += n;
                end
                8: begin
                    send_rand(rand_req(tarc_pkg::OP_FORCE));
                    done++;
                end
                default: begin
                    send_rand(rand_req(tarc_pkg::op_t'($urandom_range(0, 3))));
                    done++;
                end
            endcase
        end
    endtask

    task automatic configure(int kind);
        if (kind == 0) begin
            write_reg(tarc_pkg::REG_PROP_GAIN, 16'd0);
            write_reg(tarc_pkg::REG_INT_GAIN, 16'd0);
            write_reg(tarc_pkg::REG_STOP_BAND, 16'd0);
            write_reg(tarc_pkg::REG_START_BAND, 16'd0);
            write_reg(tarc_pkg::REG_MAX_RATE, 16'd0);
            write_reg(tarc_pkg::REG_MIN_RATE, 16'd0);
            write_reg(tarc_pkg::REG_LOCK_BAND, 16'd0);
            write_reg(tarc_pkg::REG_DEBOUNCE, 16'd0);
        end else if (kind == 1) begin
            write_reg(tarc_pkg::REG_PROP_GAIN, 16'hFFFF);
            write_reg(tarc_pkg::REG_INT_GAIN, 16'hFFFF);
            write_reg(tarc_pkg::REG_STOP_BAND, 16'd32767);
            write_reg(tarc_pkg::REG_START_BAND, 16'd32767);
            write_reg(tarc_pkg::REG_MAX_RATE, 16'd4095);
            write_reg(tarc_pkg::REG_MIN_RATE, 16'd4095);
            write_reg(tarc_pkg::REG_LOCK_BAND, 16'd32767);
            write_reg(tarc_pkg::REG_DEBOUNCE, 16'd255);
        end else begin
            write_reg(tarc_pkg::REG_PROP_GAIN, $urandom_range(0, 3) == 0 ?
                      16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 2048)));
            write_reg(tarc_pkg::REG_INT_GAIN, $urandom_range(0, 3) == 0 ?
                      16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 1024)));
            write_reg(tarc_pkg::REG_STOP_BAND, $urandom_range(0, 1) ?
                      16'($urandom_range(0, 32767)) : 16'($urandom_range(0, 200)));
            write_reg(tarc_pkg::REG_START_BAND, $urandom_range(0, 1) ?
                      16'($urandom_range(0, 32767)) : 16'($urandom_range(0, 400)));
            write_reg(tarc_pkg::REG_MAX_RATE, 16'($urandom_range(0, 4095)));
            write_reg(tarc_pkg::REG_MIN_RATE, 16'($urandom_range(0, 4095)));
            write_reg(tarc_pkg::REG_LOCK_BAND, $urandom_range(0, 1) ?
                      16'($urandom_range(0, 32767)) : 16'($urandom_range(0, 100)));
            write_reg(tarc_pkg::REG_DEBOUNCE, 16'($urandom_range(0, 6)));
        end
    endtask

    // directed table
    req_t    row_req[$];
    bit      row_typed[$];
    status_t row_want[$];

    task automatic row(tarc_pkg::op_t op, bit lost, bit zero, int err, int nm, bit en,
                       bit typed, int rate, bit dir, bit lk, logic [2:0] mode);
        req_t rq;
        status_t w;
        rq.op = op; rq.lost = lost; rq.zero = zero; rq.err = 16'(err);
        rq.ts = 16'h1000; rq.now = 32'(1000 * (row_req.size() + 1));
        rq.en = en; rq.nm = 3'(nm);
        w.rate = 12'(rate); w.dir = dir; w.lk = lk; w.mode = mode;
        row_req.push_back(rq); row_typed.push_back(typed); row_want.push_back(w);
    endtask

    initial begin
        int i, ph;
        axis_reset();
        clock_ms = 32'hFFFF_F000;
        //   op                   lost zero err   mode en chk rate dir lk mode
        row(tarc_pkg::OP_NONE,   0, 0, 0,      0, 0, 1, 0,   0, 0, tarc_pkg::MODE_IDLE);
        row(tarc_pkg::OP_FORCE,  0, 0, 0,      7, 0, 1, 0,   0, 0, tarc_pkg::MODE_IDLE);
        row(tarc_pkg::OP_FORCE,  0, 0, 0,      5, 0, 1, 0,   0, 0, tarc_pkg::MODE_SCAN);
        row(tarc_pkg::OP_UPDATE, 0, 0, 0,      0, 0, 1, 150, 1, 0, tarc_pkg::MODE_SCAN);
        row(tarc_pkg::OP_FORCE,  0, 0, 0,      2, 0, 1, 150, 1, 0, tarc_pkg::MODE_LOCK);
        row(tarc_pkg::OP_UPDATE, 0, 0, 0,      0, 0, 1, 0,   0, 1, tarc_pkg::MODE_LOCK);
        row(tarc_pkg::OP_UPDATE, 0, 0, 32767,  0, 0, 1, 100, 1, 0, tarc_pkg::MODE_LOCK);
        row(tarc_pkg::OP_FORCE,  0, 0, 0,      4, 0, 1, 100, 1, 0, tarc_pkg::MODE_TRACE);
        row(tarc_pkg::OP_UPDATE, 0, 0, -32768, 0, 0, 1, 25,  0, 0, tarc_pkg::MODE_TRACE);
        row(tarc_pkg::OP_FORCE,  0, 0, 0,      1, 0, 1, 25,  0, 0, tarc_pkg::MODE_TRACK);
        row(tarc_pkg::OP_UPDATE, 0, 0, 0,      0, 0, 1, 0,   0, 0, tarc_pkg::MODE_TRACK);
        row(tarc_pkg::OP_UPDATE, 0, 0, 300,    0, 0, 1, 50,  0, 0, tarc_pkg::MODE_TRACK);
        row(tarc_pkg::OP_FEED,   0, 1, 0,      0, 0, 1, 50,  0, 0, tarc_pkg::MODE_TRACK);
        row(tarc_pkg::OP_FEED,   1, 1, 0,      0, 0, 0, 0,   0, 0, tarc_pkg::MODE_IDLE);
        row(tarc_pkg::OP_FEED,   0, 0, 0,      0, 0, 0, 0,   0, 0, tarc_pkg::MODE_IDLE);
        row(tarc_pkg::OP_UPDATE, 0, 0, -5000,  0, 1, 0, 0,   0, 0, tarc_pkg::MODE_IDLE);
        row(tarc_pkg::OP_FORCE,  0, 0, 0,      0, 0, 1, 50,  0, 0, tarc_pkg::MODE_IDLE);
        row(tarc_pkg::OP_UPDATE, 0, 0, 1000,   0, 1, 1, 0,   0, 0, tarc_pkg::MODE_IDLE);
        row(tarc_pkg::OP_FORCE,  0, 0, 0,      6, 0, 1, 0,   0, 0, tarc_pkg::MODE_IDLE);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        calm = 1;
        for (i = 0; i < row_req.size(); i++) send(row_req[i], row_typed[i], row_want[i]);
        calm = 0;

        for (ph = 0; ph < 9; ph++) begin
            drain();
            configure(ph == 0 ? 0 : ph == 1 ? 1 : 2);
            calm = (ph == 4);
            run_phase(ph == 1 ? 200 : 80);
        end
        drain();

        if (errors == 0) $display("tracking_axis_rate_controller_unit_tb: clean");
        else $display("tracking_axis_rate_controller_unit_tb: errors");
        $finish;
    end

endmodule
